[src/cfp_pkg.sv]
// Shared types and constants for the CAN signal frame packer.
`timescale 1ns / 1ps

package cfp_pkg;

  localparam int FRAME_W   = 64;
  localparam int VALUE_W   = 48;
  localparam int FACTOR_W  = 32;
  localparam int START_W   = 6;
  localparam int LEN_W     = 7;
  localparam int FLEN_W    = 4;
  localparam int MAG_W     = VALUE_W + 1;
  localparam int NUM_W     = MAG_W + 1;
  localparam int DEN_W     = FACTOR_W + 1;
  localparam int CNT_W     = $clog2(NUM_W);
  localparam int FLEN_RESET = 8;

  typedef struct packed {
    logic load;
    logic step;
    logic sat;
    logic place;
    logic emit;
  } cfp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } cfp_sts_t;

endpackage

[src/cfp_if.sv]
// Request channels of the frame packer: signal requests in, frames out.
`timescale 1ns / 1ps

interface cfp_in_if import cfp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  phys_value;
  logic signed [VALUE_W-1:0]  signal_offset;
  logic [FACTOR_W-1:0]        scale_factor;
  logic [START_W-1:0]         start_bit;
  logic [LEN_W-1:0]           bit_length;
  logic                       little_endian;
  logic                       last_signal;

  modport source (
    output valid, phys_value, signal_offset, scale_factor, start_bit, bit_length,
           little_endian, last_signal,
    input  ready
  );
  modport sink (
    input  valid, phys_value, signal_offset, scale_factor, start_bit, bit_length,
           little_endian, last_signal,
    output ready
  );
endinterface

interface cfp_out_if import cfp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_data;
  logic               clamped_any;

  modport source (output valid, frame_data, clamped_any, input ready);
  modport sink   (input valid, frame_data, clamped_any, output ready);
endinterface

[src/can_signal_frame_packer.sv]
// Top level of the CAN signal frame packer.
`timescale 1ns / 1ps
//
// Packs DBC signals into a CAN frame. Each request on sig_in carries one
// signal: value and offset in signed Q31.16, factor in unsigned Q16.16,
// start bit, length, byte order and a last flag. The raw value
// round((value - offset) / factor) is saturated to [0, 2^length - 1] and
// written into a 64-bit frame buffer in Intel or Motorola layout; bits at
// or past 8 * frame_length are dropped. A request marked last puts the
// frame, bytes past frame_length zeroed, and the saturation flag on
// frame_out, then clears the buffer and flag.
// frame_length is written through cfg_we / cfg_data; the user must do so
// only while the block is idle, which the block does not enforce. Each
// request passes through accept, 50 steps of the serial radix-2 divider,
// saturate and place; a last request adds an emit step. The output register
// lets the next request in while a frame waits; a further last request
// holds in its emit step until frame_out is taken. Reset clears the buffer,
// the flag and the output valid, and sets frame_length 8.
module can_signal_frame_packer import cfp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [FLEN_W-1:0] cfg_data,
  cfp_in_if.sink            sig_in,
  cfp_out_if.source         frame_out
);

  cfp_cmd_t cmd;
  cfp_sts_t sts;
  logic     in_ready;

  assign sig_in.ready = in_ready;

  cfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sig_in.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfp_datapath #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .phys_value    (sig_in.phys_value),
    .signal_offset (sig_in.signal_offset),
    .scale_factor  (sig_in.scale_factor),
    .start_bit     (sig_in.start_bit),
    .bit_length    (sig_in.bit_length),
    .little_endian (sig_in.little_endian),
    .last_signal   (sig_in.last_signal),
    .out_ready     (frame_out.ready),
    .out_valid     (frame_out.valid),
    .out_frame     (frame_out.frame_data),
    .out_clamp     (frame_out.clamped_any)
  );

endmodule

[src/cfp_ctrl.sv]
// Sequencer of the frame packer: accept, divide, saturate, place, emit.
`timescale 1ns / 1ps

module cfp_ctrl import cfp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  cfp_sts_t sts,
  output cfp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SAT   = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(NUM_W - 1);

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] step_cnt;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (step_cnt == STEP_LAST) state_next = S_SAT;
      end
      S_SAT: begin
        cmd.sat    = 1'b1;
        state_next = S_PLACE;
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) step_cnt <= step_cnt + 1'b1;
      else                step_cnt <= '0;
    end
  end

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && step_cnt == STEP_LAST |=> state == S_SAT)
    else $error("division did not hand over to saturation");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DIV && step_cnt == '0)
    else $error("accepted request did not start the divider");

endmodule

[src/cfp_datapath.sv]
// Datapath of the frame packer: serial divider, saturation, bit placement, output register.
`timescale 1ns / 1ps

module cfp_datapath import cfp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [FLEN_W-1:0]         cfg_data,
  input  cfp_cmd_t                  cmd,
  output cfp_sts_t                  sts,
  input  logic signed [VALUE_W-1:0] phys_value,
  input  logic signed [VALUE_W-1:0] signal_offset,
  input  logic [FACTOR_W-1:0]       scale_factor,
  input  logic [START_W-1:0]        start_bit,
  input  logic [LEN_W-1:0]          bit_length,
  input  logic                      little_endian,
  input  logic                      last_signal,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [FRAME_W-1:0]        out_frame,
  output logic                      out_clamp
);

  function automatic logic [FRAME_W-1:0] len_mask(input logic [LEN_W-1:0] n);
    logic [FRAME_W-1:0] m;
    m = (n >= LEN_W'(FRAME_W)) ? '1 : ((FRAME_W'(1) << n) - 1'b1);
    return m;
  endfunction

  function automatic logic [FRAME_W-1:0] byte_mask(input logic [FLEN_W-1:0] n);
    logic [FRAME_W-1:0] m;
    m = (n >= FLEN_W'(8)) ? '1 : ((FRAME_W'(1) << {n, 3'b000}) - 1'b1);
    return m;
  endfunction

  function automatic logic [FRAME_W-1:0] byte_swap(input logic [FRAME_W-1:0] v);
    logic [FRAME_W-1:0] r;
    for (int k = 0; k < 8; k++) r[8*k +: 8] = v[8*(7-k) +: 8];
    return r;
  endfunction

  localparam logic [FLEN_W-1:0] FLEN_MAX = FLEN_W'(MAX_FRAME_BYTES);

  logic [FLEN_W-1:0]  frame_length;
  logic [NUM_W-1:0]   num;
  logic [DEN_W-1:0]   den;
  logic [DEN_W-1:0]   rem;
  logic [NUM_W-1:0]   quo;
  logic               diff_neg;
  logic [START_W-1:0] start;
  logic [LEN_W-1:0]   len;
  logic               intel;
  logic               last;
  logic [FRAME_W-1:0] raw;
  logic [FRAME_W-1:0] fmask;
  logic [FRAME_W-1:0] frame_buffer;
  logic               clamp_seen;

  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]        mag;
  logic [FACTOR_W-1:0]     f_eff;
  logic [DEN_W:0]          rem_sh;
  logic                    rem_ge;
  logic [FRAME_W-1:0]      q64;
  logic [FRAME_W-1:0]      maxv;
  logic [FLEN_W-1:0]       active;
  logic [FRAME_W-1:0]      lim;
  logic [START_W-1:0]      msb_lin;
  logic [7:0]              sh;
  logic [7:0]              sh_neg;
  logic [FRAME_W-1:0]      mot_val;
  logic [FRAME_W-1:0]      mot_msk;
  logic [FRAME_W-1:0]      val;
  logic [FRAME_W-1:0]      msk;

  always_comb begin
    diff   = MAG_W'(phys_value) - MAG_W'(signal_offset);
    mag    = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    f_eff  = (scale_factor == '0) ? FACTOR_W'(1) : scale_factor;
    rem_sh = {rem, num[NUM_W-1]};
    rem_ge = rem_sh >= {1'b0, den};
    q64    = FRAME_W'(quo);
    maxv   = len_mask(len);
    active = (frame_length > FLEN_MAX) ? FLEN_MAX : frame_length;
    lim    = byte_mask(active);
    msb_lin = start ^ START_W'(7);
    sh      = 8'd64 - {2'b00, msb_lin} - {1'b0, len};
    sh_neg  = 8'd0 - sh;
    if (sh[7]) begin
      mot_val = raw >> sh_neg[6:0];
      mot_msk = fmask >> sh_neg[6:0];
    end else begin
      mot_val = raw << sh[6:0];
      mot_msk = fmask << sh[6:0];
    end
    if (intel) begin
      val = raw << start;
      msk = fmask << start;
    end else begin
      val = byte_swap(mot_val);
      msk = byte_swap(mot_msk);
    end
    msk = msk & lim;
  end

  assign sts.last     = last;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      diff_neg <= diff[MAG_W-1];
      num      <= {mag, 1'b0} + NUM_W'(f_eff);
      den      <= {f_eff, 1'b0};
      rem      <= '0;
      quo      <= '0;
      start    <= start_bit;
      len      <= (bit_length > LEN_W'(FRAME_W)) ? LEN_W'(FRAME_W) : bit_length;
      intel    <= little_endian;
      last     <= last_signal;
    end else if (cmd.step) begin
      num <= num << 1;
      rem <= rem_ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], rem_ge};
    end
    if (cmd.sat) begin
      fmask <= maxv;
      if (diff_neg)       raw <= '0;
      else if (q64 > maxv) raw <= maxv;
      else                raw <= q64;
    end
    if (cmd.emit) begin
      out_frame <= frame_buffer & lim;
      out_clamp <= clamp_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= FLEN_W'(FLEN_RESET);
      frame_buffer <= '0;
      clamp_seen   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) frame_length <= cfg_data;
      if (cmd.sat && ((diff_neg && quo != '0) || (!diff_neg && q64 > maxv)))
        clamp_seen <= 1'b1;
      if (cmd.place) frame_buffer <= (frame_buffer & ~msk) | (val & msk);
      if (cmd.emit) begin
        frame_buffer <= '0;
        clamp_seen   <= 1'b0;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> frame_buffer == '0 && !clamp_seen && out_valid)
    else $error("emit did not clear the buffer or load the output");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid || out_ready)
    else $error("emit while the output register was still full");

  a_load_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> rem == '0 && quo == '0 && den != '0)
    else $error("divider not started clean");

endmodule

[verif/tb_can_signal_frame_packer.sv]
// Testbench for can_signal_frame_packer: directed and random signal requests against a scoreboard.
`timescale 1ns / 1ps

module tb_can_signal_frame_packer;
  import cfp_pkg::*;

  localparam int          MAX_FRAME_BYTES = 8;
  localparam int          SETTLE_CYCLES   = 64;
  localparam int unsigned LIMIT_CYCLES    = 1_000_000;
  localparam longint      ONE             = 64'sd65536;
  localparam longint      VMAX            = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      VMIN            = -64'sh0000_8000_0000_0000;

  typedef struct {
    logic signed [VALUE_W-1:0] phys_value;
    logic signed [VALUE_W-1:0] signal_offset;
    logic [FACTOR_W-1:0]       scale_factor;
    logic [START_W-1:0]        start_bit;
    logic [LEN_W-1:0]          bit_length;
    logic                      little_endian;
    logic                      last_signal;
  } sig_req_t;

  typedef struct {
    logic [FRAME_W-1:0] frame_data;
    logic               clamped_any;
  } frame_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [FLEN_W-1:0] cfg_data;

  cfp_in_if  sig_in ();
  cfp_out_if frame_out ();

  can_signal_frame_packer #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .sig_in    (sig_in),
    .frame_out (frame_out)
  );

  logic [FRAME_W-1:0] frame_buf;
  logic               clamp_flag;
  logic [FLEN_W-1:0]  frame_len_reg;
  frame_t             frames_due[$];
  frame_t             due_frame;

  int unsigned err_cnt;
  int unsigned req_cnt;
  int unsigned frame_cnt;
  int unsigned cfg_cnt;
  int unsigned cycle_cnt;
  int unsigned hold_off_cycles;
  bit          jitter_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sig_req_t signal_of(input longint phys, input longint offs,
                                         input logic [FACTOR_W-1:0] fac, input int start,
                                         input int len, input bit intel, input bit last);
    sig_req_t r;
    r.phys_value    = phys[VALUE_W-1:0];
    r.signal_offset = offs[VALUE_W-1:0];
    r.scale_factor  = fac;
    r.start_bit     = START_W'(start);
    r.bit_length    = LEN_W'(len);
    r.little_endian = intel;
    r.last_signal   = last;
    return r;
  endfunction

  // Well-formed: raw in range, or at times just over or negative; else all but last is random.
  function automatic sig_req_t random_signal(input bit well_formed, input bit last);
    logic [FACTOR_W-1:0] fac;
    logic [63:0]         raw;
    logic [63:0]         maxv;
    longint              diff;
    longint              offs;
    int                  len;
    int                  room;
    int unsigned         sel;
    if (!well_formed)
      return signal_of(longint'({$urandom, $urandom}), longint'({$urandom, $urandom}),
                       $urandom, $urandom_range(0, 63), $urandom_range(0, 127),
                       $urandom_range(0, 1), last);
    fac  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'hFFFF_FFFF)
                                       : $urandom_range(1, 32'h0010_0000);
    room = 46 - $clog2(longint'(fac) + 1);
    len  = $urandom_range(1, 64);
    maxv = (len == 64) ? '1 : (64'd1 << len) - 64'd1;
    if (room < 64) maxv = maxv & ((64'd1 << room) - 64'd1);
    sel  = $urandom_range(0, 9);
    raw  = {$urandom, $urandom} & maxv;
    if (sel == 1 && len < room) raw = 64'd1 << len;
    if (sel == 2) raw = maxv;
    diff = longint'(raw * fac) + longint'($urandom_range(0, fac - 1)) - longint'(fac / 2);
    if (sel == 0) diff = -diff - longint'(fac);
    offs = longint'({$urandom, $urandom}) >>> 18;
    return signal_of(offs + diff, offs, fac, $urandom_range(0, 63), len,
                     $urandom_range(0, 1), last);
  endfunction

  task automatic pack_signal(input sig_req_t req);
    logic [VALUE_W:0] diff;
    logic [VALUE_W:0] ndiff;
    logic [63:0]      mag;
    logic [63:0]      fac;
    logic [63:0]      quot;
    logic [63:0]      maxv;
    logic [63:0]      raw;
    logic [63:0]      mask;
    int unsigned      len;
    int unsigned      nbytes;
    int unsigned      lim;
    int unsigned      pos;
    frame_t           frm;
    diff = {req.phys_value[VALUE_W-1], req.phys_value}
         - {req.signal_offset[VALUE_W-1], req.signal_offset};
    ndiff = ~diff + 1'b1;
    mag  = diff[VALUE_W] ? 64'(ndiff) : 64'(diff);
    fac  = (req.scale_factor == '0) ? 64'd1 : 64'(req.scale_factor);
    quot = (mag * 2 + fac) / (fac * 2);
    len  = (req.bit_length > 64) ? 64 : req.bit_length;
    maxv = (len == 64) ? '1 : (64'd1 << len) - 64'd1;
    if (diff[VALUE_W] && quot != 0) begin
      raw        = '0;
      clamp_flag = 1'b1;
    end else if (!diff[VALUE_W] && quot > maxv) begin
      raw        = maxv;
      clamp_flag = 1'b1;
    end else begin
      raw = diff[VALUE_W] ? 64'd0 : quot;
    end
    nbytes = (frame_len_reg > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : frame_len_reg;
    lim    = 8 * nbytes;
    pos    = req.start_bit;
    for (int unsigned b = 0; b < len; b++) begin
      if (req.little_endian) begin
        pos = req.start_bit + b;
        if (pos < lim && pos < 64) frame_buf[pos] = raw[b];
      end else begin
        if (pos < lim && pos < 64) frame_buf[pos] = raw[len - 1 - b];
        pos = (pos % 8 == 0) ? pos + 15 : pos - 1;
      end
    end
    if (req.last_signal) begin
      mask            = (nbytes >= 8) ? '1 : (64'd1 << lim) - 64'd1;
      frm.frame_data  = frame_buf & mask;
      frm.clamped_any = clamp_flag;
      frames_due.push_back(frm);
      frame_buf  = '0;
      clamp_flag = 1'b0;
    end
  endtask

  task automatic send_signal(input sig_req_t req);
    int unsigned gap;
    gap = jitter_on ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      sig_in.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sig_in.valid         <= 1'b1;
    sig_in.phys_value    <= req.phys_value;
    sig_in.signal_offset <= req.signal_offset;
    sig_in.scale_factor  <= req.scale_factor;
    sig_in.start_bit     <= req.start_bit;
    sig_in.bit_length    <= req.bit_length;
    sig_in.little_endian <= req.little_endian;
    sig_in.last_signal   <= req.last_signal;
    do @(posedge clk); while (!sig_in.ready);
    pack_signal(req);
    req_cnt++;
  endtask

  // Drop valid, drain the frames owed, then let any non-last request finish.
  task automatic wait_idle();
    @(negedge clk);
    sig_in.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_length(input logic [FLEN_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    frame_len_reg = value;
    cfg_cnt++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_byte_orders();
    send_signal(signal_of('hA5 * ONE, 0, ONE, 0, 8, 1, 1));
    send_signal(signal_of('h1234 * ONE, 0, ONE, 7, 16, 0, 1));
    send_signal(signal_of('h2AB * ONE, 0, ONE, 61, 10, 1, 1));
    send_signal(signal_of('hABC * ONE, 0, ONE, 56, 12, 0, 1));
    send_signal(signal_of(VMAX, VMIN, 1, 63, 64, 1, 1));
    send_signal(signal_of(5 * ONE, 0, ONE, 0, 4, 1, 0));
    send_signal(signal_of('hC3 * ONE, 0, ONE, 15, 8, 0, 0));
    send_signal(signal_of('hF * ONE, 0, ONE, 2, 4, 1, 1));
  endtask

  task automatic test_saturation();
    send_signal(signal_of('h8000, 0, ONE, 0, 8, 1, 1));
    send_signal(signal_of('h7FFF, 0, ONE, 8, 8, 1, 1));
    send_signal(signal_of(0, 'h8000, ONE, 0, 8, 1, 1));
    send_signal(signal_of(0, 'h7FFF, ONE, 0, 8, 1, 1));
    send_signal(signal_of(100 * ONE, 0, ONE, 4, 4, 1, 0));
    send_signal(signal_of(3 * ONE, 0, ONE, 0, 4, 1, 1));
    send_signal(signal_of(7, 0, 0, 0, 8, 1, 1));
    send_signal(signal_of(ONE, 0, ONE, 0, 0, 1, 1));
    send_signal(signal_of(VMAX, VMIN, 1, 0, 127, 1, 1));
    send_signal(signal_of(VMIN, VMAX, 32'hFFFF_FFFF, 0, 64, 0, 1));
    send_signal(signal_of(VMIN, VMIN, 32'hFFFF_FFFF, 5, 3, 0, 1));
  endtask

  task automatic test_frame_length();
    wait_idle();
    write_frame_length(4'd0);
    send_signal(signal_of(VMAX, VMIN, 1, 0, 64, 1, 1));
    wait_idle();
    write_frame_length(4'd3);
    send_signal(signal_of('hBEEF * ONE, 0, ONE, 16, 16, 1, 1));
    wait_idle();
    write_frame_length(4'd15);
    send_signal(signal_of('h96 * ONE, 0, ONE, 63, 8, 0, 1));
    wait_idle();
    write_frame_length(4'd8);
    send_signal(signal_of('h5A * ONE, 0, ONE, 48, 8, 1, 0));
    wait_idle();
    write_frame_length(4'd2);
    send_signal(signal_of('h11 * ONE, 0, ONE, 0, 8, 1, 1));
    wait_idle();
    write_frame_length(4'd8);
  endtask

  task automatic test_backpressure();
    wait_idle();
    jitter_on       = 1'b0;
    hold_off_cycles = 800;
    repeat (16) send_signal(random_signal(1'b1, 1'b1));
    wait_idle();
    jitter_on = 1'b1;
    repeat (8) send_signal(random_signal(1'b1, $urandom_range(0, 1)));
  endtask

  task automatic test_random_frames(input int unsigned n_items);
    logic [FLEN_W-1:0] lengths[6];
    int unsigned       per_phase;
    int unsigned       sent;
    int unsigned       nsig;
    bit                well_formed;
    lengths   = '{4'd8, 4'($urandom_range(1, 7)), 4'd0, 4'd15,
                  4'($urandom_range(9, 14)), 4'd8};
    per_phase = n_items / 6;
    foreach (lengths[ph]) begin
      wait_idle();
      write_frame_length(lengths[ph]);
      sent = 0;
      while (sent < per_phase) begin
        if ($urandom_range(0, 19) == 0) jitter_on = !jitter_on;
        nsig = $urandom_range(1, 5);
        for (int unsigned k = 0; k < nsig; k++) begin
          well_formed = ($urandom_range(0, 4) != 0);
          send_signal(random_signal(well_formed,
                                    well_formed ? (k == nsig - 1) : $urandom_range(0, 1)));
          sent++;
        end
      end
    end
    jitter_on = 1'b1;
  endtask

  initial begin
    logic         nxt;
    int unsigned  stall_left;
    frame_out.ready = 1'b0;
    stall_left      = 0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        nxt = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b0;
      end else if (!jitter_on || $urandom_range(0, 99) < 70) begin
        nxt = 1'b1;
      end else begin
        stall_left = idle_len();
        nxt        = 1'b0;
      end
      frame_out.ready <= nxt;
    end
  end

  always @(posedge clk) begin
    if (!rst && frame_out.valid && frame_out.ready) begin
      if (frames_due.size() == 0) begin
        err_cnt++;
        $error("frame_out: frame %h with no request owing one", frame_out.frame_data);
      end else begin
        due_frame = frames_due.pop_front();
        frame_cnt++;
        if (frame_out.frame_data !== due_frame.frame_data) begin
          err_cnt++;
          $error("frame_data: expected %h, got %h", due_frame.frame_data,
                 frame_out.frame_data);
        end
        if (frame_out.clamped_any !== due_frame.clamped_any) begin
          err_cnt++;
          $error("clamped_any: expected %b, got %b", due_frame.clamped_any,
                 frame_out.clamped_any);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d frames still owed", cycle_cnt,
               frames_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    err_cnt              = 0;
    req_cnt              = 0;
    frame_cnt            = 0;
    cfg_cnt              = 0;
    cycle_cnt            = 0;
    hold_off_cycles      = 0;
    jitter_on            = 1'b1;
    frame_buf            = '0;
    clamp_flag           = 1'b0;
    frame_len_reg        = FLEN_W'(FLEN_RESET);
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_data             = '0;
    sig_in.valid         = 1'b0;
    sig_in.phys_value    = '0;
    sig_in.signal_offset = '0;
    sig_in.scale_factor  = '0;
    sig_in.start_bit     = '0;
    sig_in.bit_length    = '0;
    sig_in.little_endian = 1'b0;
    sig_in.last_signal   = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_byte_orders();
    test_saturation();
    test_frame_length();
    test_backpressure();
    test_random_frames(1490);
    wait_idle();

    if (frames_due.size() != 0) begin
      err_cnt++;
      $error("%0d frames never arrived", frames_due.size());
    end
    $display("Sent %0d signal requests, checked %0d frames over %0d frame length writes",
             req_cnt, frame_cnt, cfg_cnt);
    $display("Covered both byte orders, saturation, zero factor, odd lengths, output hold-off");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
